// ===== hdl/stereo_peak_meter_auto_range_assert.svh =====
// ----------------------------------------------------------------------------
// spmar assertion macros
// assertion forms for the peak meter controller
// ----------------------------------------------------------------------------
`ifndef STEREO_PEAK_METER_AUTO_RANGE_ASSERT_SVH
`define STEREO_PEAK_METER_AUTO_RANGE_ASSERT_SVH

// implication checked every clock, quiet in reset
`define SPMAR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spmar check failed");

// next-cycle implication
`define SPMAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spmar check failed");

`endif

// ===== hdl/spmar_pkg.sv =====
// ----------------------------------------------------------------------------
// spmar_pkg
// shared types and constants of the stereo peak meter
// ----------------------------------------------------------------------------
package spmar_pkg;

   localparam int BarCountDefault      = 8;
   localparam int SubsampleTapsDefault = 64;

   localparam logic [15:0] FloorPeakReset    = 16'd4096;
   localparam logic [3:0]  DecayShiftReset   = 4'd5;
   localparam logic [15:0] StaleWindowReset  = 16'd260;
   localparam logic [15:0] RefreshPeriodReset = 16'd33;
   localparam logic [6:0]  RiseMinReset      = 7'd6;
   localparam logic [6:0]  FallMinReset      = 7'd3;
   localparam logic [15:0] FullScaleReset    = 16'd4096;

   localparam logic [2:0] CSR_FLOOR   = 3'd0;
   localparam logic [2:0] CSR_DECAY   = 3'd1;
   localparam logic [2:0] CSR_STALE   = 3'd2;
   localparam logic [2:0] CSR_REFRESH = 3'd3;
   localparam logic [2:0] CSR_RISE    = 3'd4;
   localparam logic [2:0] CSR_FALL    = 3'd5;

   localparam logic FUNC_FRAME   = 1'b0;
   localparam logic FUNC_REFRESH = 1'b1;
   localparam logic KIND_LEVELS  = 1'b0;
   localparam logic KIND_BAR     = 1'b1;

   localparam int DivBits = 24;

   typedef struct packed {
      logic        func;
      logic [15:0] left_sample;
      logic [15:0] right_sample;
      logic [14:0] buffer_frames;
      logic        last_frame;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [6:0] left_percent;
      logic [6:0] right_percent;
      logic [2:0] bar_index;
      logic [6:0] bar_level;
      logic [5:0] bar_height;
      logic       bar_changed;
      logic       signal_fresh;
      logic       last_result;
   } rsp_type;

   typedef struct packed {
      logic [15:0] floor_peak;
      logic [3:0]  decay_shift;
      logic [15:0] stale_window_ms;
      logic [15:0] refresh_period_ms;
      logic [6:0]  rise_min_step;
      logic [6:0]  fall_min_step;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic frame_load;   // register item, run frame peak update
      logic scale_sel;    // 0 left, 1 right
      logic scale_run;    // update full scale and start divide
      logic div_step;
      logic level_store;
      logic end_buffer;
      logic refresh_load;
      logic bar_step;
      logic rsp_load_levels;
      logic rsp_load_bar;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_refresh;
      logic is_last;
      logic refresh_ok;
      logic div_done;
      logic bar_last;
   } sts_type;

   function automatic logic [15:0] magnitude(input logic [15:0] s);
      logic [16:0] m;
      m = s[15] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
      return m[15:0] | {m[16], 15'd0};
   endfunction

endpackage

// ===== hdl/spmar_if.sv =====
// ----------------------------------------------------------------------------
// spmar_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface spmar_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/spmar_ctrl.sv =====
// ----------------------------------------------------------------------------
// spmar_ctrl
// sequencer for frame, buffer end and bar refresh work
// ----------------------------------------------------------------------------
module spmar_ctrl
   import spmar_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    rsp_busy,
   input  sts_type sts,
   output cmd_type cmd
);

   `include "stereo_peak_meter_auto_range_assert.svh"

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_SCALE  = 7'b0000100,
      ST_DIV    = 7'b0001000,
      ST_LEVOUT = 7'b0010000,
      ST_BAR    = 7'b0100000,
      ST_BAROUT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      side_ff, side_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         side_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      side_in   = side_ff;
      cmd       = '0;
      req_ready = 1'b0;
      cmd.scale_sel = side_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.frame_load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.is_refresh) begin
               if (sts.refresh_ok) begin
                  cmd.refresh_load = 1'b1;
                  state_in = ST_BAR;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (sts.is_last) begin
               side_in  = 1'b0;
               state_in = ST_SCALE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCALE: begin
            cmd.scale_run = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.level_store = 1'b1;
               if (side_ff) begin
                  state_in = ST_LEVOUT;
               end else begin
                  side_in  = 1'b1;
                  state_in = ST_SCALE;
               end
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_LEVOUT: begin
            if (!rsp_busy) begin
               cmd.rsp_load_levels = 1'b1;
               cmd.end_buffer = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_BAR: begin
            state_in = ST_BAROUT;
         end
         ST_BAROUT: begin
            if (!rsp_busy) begin
               cmd.rsp_load_bar = 1'b1;
               cmd.bar_step = 1'b1;
               state_in = sts.bar_last ? ST_IDLE : ST_BAR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `SPMAR_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE)
   `SPMAR_ASSERT_NEXT(a_load_decode, clock, reset, cmd.frame_load, state_ff == ST_DECODE)
   `SPMAR_ASSERT_IMP(a_one_load, clock, reset, 1'b1, !(cmd.rsp_load_levels && cmd.rsp_load_bar))

endmodule

// ===== hdl/spmar_dp.sv =====
// ----------------------------------------------------------------------------
// spmar_dp
// peak tracking, full scale, serial percent divider and bar smoothing
// ----------------------------------------------------------------------------
module spmar_dp
   import spmar_pkg::*;
#(
   parameter int BAR_COUNT      = BarCountDefault,
   parameter int SUBSAMPLE_TAPS = SubsampleTapsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cfg_type cfg,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_item
);

   localparam int BarBits  = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;
   localparam int StepBits = 15;
   // step by reciprocal multiply, exact for 15-bit frame counts
   localparam int TapBits    = $clog2(SUBSAMPLE_TAPS);
   localparam int RecipShift = StepBits + TapBits;
   localparam int RecipMul   = ((1 << RecipShift) + SUBSAMPLE_TAPS - 1) / SUBSAMPLE_TAPS;

   req_type       item_ff;
   logic [15:0]   fs_ff, fs_in;
   logic [15:0]   lpk_ff, rpk_ff;
   logic [StepBits-1:0] step_ff, skip_ff;
   logic          inbuf_ff;
   logic [6:0]    llev_ff, rlev_ff;
   logic [31:0]   sig_time_ff, ref_time_ff;
   logic [6:0]    bars_ff [BAR_COUNT];
   logic [BarBits-1:0] bar_ff;
   logic          fresh_ff;
   logic [6:0]    tgt_ff;

   // divider
   logic [DivBits-1:0] rem_ff, quo_ff;
   logic [15:0]   den_ff;
   logic [4:0]    cnt_ff;

   // frame path
   logic [14:0]   frames;
   logic [31:0]   st_prod;
   logic [StepBits-1:0] st, step_eff, skip_eff, skip_nx;
   logic [15:0]   lmag, rmag, lbase, rbase;

   assign frames   = req_data.buffer_frames;
   assign st_prod  = {17'd0, frames} * 32'(RecipMul);
   assign st       = StepBits'(st_prod >> RecipShift);
   assign step_eff = inbuf_ff ? step_ff : ((st == '0) ? StepBits'(1) : st);
   assign skip_eff = inbuf_ff ? skip_ff : '0;
   assign skip_nx  = ((skip_eff + 1'b1) >= step_eff) ? '0 : skip_eff + 1'b1;
   assign lmag     = magnitude(req_data.left_sample);
   assign rmag     = magnitude(req_data.right_sample);
   assign lbase    = inbuf_ff ? lpk_ff : '0;
   assign rbase    = inbuf_ff ? rpk_ff : '0;

   // full scale update
   logic [15:0] peak, fl, decay, dyn;
   logic [16:0] dsum;
   always_comb begin
      peak  = cmd.scale_sel ? rpk_ff : lpk_ff;
      fl    = (cfg.floor_peak == '0) ? 16'd1 : cfg.floor_peak;
      decay = fs_ff >> cfg.decay_shift;
      dsum  = {1'b0, decay} + {1'b0, fl};
      if (peak > fs_ff) begin
         dyn = peak;
      end else begin
         dyn = ({1'b0, fs_ff} > dsum) ? (fs_ff - decay) : fl;
         if (peak > dyn) dyn = peak;
      end
      if (dyn < fl) dyn = fl;
      fs_in = dyn;
   end

   // restoring divide step
   logic [DivBits:0]   trial;
   logic [DivBits-1:0] rem_sh;
   logic [6:0]         pct;
   assign rem_sh = {rem_ff[DivBits-2:0], quo_ff[DivBits-1]};
   assign trial  = {1'b0, rem_sh} - {{(DivBits-15){1'b0}}, den_ff};
   assign pct    = (quo_ff > DivBits'(100)) ? 7'd100 : quo_ff[6:0];

   // refresh checks
   logic [31:0] since_sig;
   logic        fresh_now;
   assign since_sig = item_ff.time_ms - sig_time_ff;
   assign fresh_now = (sig_time_ff != '0) && (since_sig <= {16'd0, cfg.stale_window_ms});

   // bar target, selected by index
   logic [8:0] lv, tgt_w;
   always_comb begin
      lv = {2'b0, (bar_ff < BarBits'(BAR_COUNT / 2)) ? llev_ff : rlev_ff};
      case (bar_ff)
         3'd0, 3'd7: tgt_w = 9'(({7'd0, lv} * 16'd86) >> 8);
         3'd1, 3'd6: tgt_w = lv >> 1;
         3'd2, 3'd5: tgt_w = (lv * 9'd3) >> 2;
         default:    tgt_w = lv;
      endcase
   end

   // smoothing
   logic [6:0] cur, nxt, ris, fstp;
   logic [7:0] diff, half;
   logic [16:0] h30;
   always_comb begin
      cur  = bars_ff[bar_ff];
      nxt  = cur;
      diff = '0;
      half = '0;
      fstp = '0;
      ris  = '0;
      if (cur < tgt_ff) begin
         nxt = tgt_ff;
      end else if (cur > tgt_ff) begin
         diff = {1'b0, cur} - {1'b0, tgt_ff};
         half = (diff + 8'd1) >> 1;
         fstp = (half[6:0] > cfg.fall_min_step) ? half[6:0] : cfg.fall_min_step;
         ris  = cur - tgt_ff;
         nxt  = (fstp < ris) ? cur - fstp : tgt_ff;
      end
      h30 = ({10'd0, nxt} * 17'd1230) >> 12;
   end

   // result words
   rsp_type lev_rsp, bar_rsp;
   always_comb begin
      lev_rsp = '0;
      lev_rsp.kind = KIND_LEVELS;
      lev_rsp.left_percent = llev_ff;
      lev_rsp.right_percent = rlev_ff;
      lev_rsp.last_result = 1'b1;
      bar_rsp = '0;
      bar_rsp.kind = KIND_BAR;
      bar_rsp.bar_index = 3'(bar_ff);
      bar_rsp.bar_level = nxt;
      bar_rsp.bar_height = 6'(6'd4 + h30[5:0]);
      bar_rsp.bar_changed = (nxt != cur);
      bar_rsp.signal_fresh = fresh_ff;
      bar_rsp.last_result = (bar_ff == BarBits'(BAR_COUNT - 1));
   end

   always_ff @(posedge clock) begin
      if (cmd.frame_load) item_ff <= req_data;
      if (cmd.scale_run) begin
         den_ff <= fs_in;
         rem_ff <= '0;
         quo_ff <= DivBits'(peak) * DivBits'(100);
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial[DivBits] ? rem_sh : trial[DivBits-1:0];
         quo_ff <= {quo_ff[DivBits-2:0], ~trial[DivBits]};
         cnt_ff <= cnt_ff + 5'd1;
      end
      if (cmd.refresh_load) begin
         fresh_ff <= fresh_now;
      end
   end

   logic [6:0] tsel;
   assign tsel = fresh_ff ? tgt_w[6:0] : 7'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff <= FullScaleReset;
         lpk_ff <= '0;
         rpk_ff <= '0;
         step_ff <= '0;
         skip_ff <= '0;
         inbuf_ff <= 1'b0;
         llev_ff <= '0;
         rlev_ff <= '0;
         sig_time_ff <= '0;
         ref_time_ff <= '0;
         bar_ff <= '0;
         for (int i = 0; i < BAR_COUNT; i++) bars_ff[i] <= '0;
         rsp_item <= '0;
      end else begin
         if (cmd.frame_load && req_data.func == FUNC_FRAME) begin
            step_ff <= step_eff;
            skip_ff <= skip_nx;
            inbuf_ff <= 1'b1;
            lpk_ff <= (skip_eff == '0 && lmag > lbase) ? lmag : lbase;
            rpk_ff <= (skip_eff == '0 && rmag > rbase) ? rmag : rbase;
         end
         if (cmd.scale_run) fs_ff <= fs_in;
         if (cmd.level_store) begin
            if (cmd.scale_sel) rlev_ff <= pct;
            else llev_ff <= pct;
         end
         if (cmd.end_buffer) begin
            inbuf_ff <= 1'b0;
            sig_time_ff <= item_ff.time_ms;
         end
         if (cmd.refresh_load) begin
            ref_time_ff <= item_ff.time_ms;
            bar_ff <= '0;
         end
         if (cmd.rsp_load_levels) begin
            rsp_item <= lev_rsp;
         end else if (cmd.rsp_load_bar) begin
            bars_ff[bar_ff] <= nxt;
            rsp_item <= bar_rsp;
         end
         if (cmd.bar_step) bar_ff <= bar_ff + 1'b1;
      end
      if (cmd.refresh_load) tgt_ff <= '0;
      else if (!cmd.rsp_load_bar) tgt_ff <= tsel;
   end

   assign sts.is_refresh = item_ff.func == FUNC_REFRESH;
   assign sts.is_last    = item_ff.last_frame;
   assign sts.refresh_ok = (item_ff.time_ms - ref_time_ff) >= {16'd0, cfg.refresh_period_ms};
   assign sts.div_done   = cnt_ff == 5'(DivBits);
   assign sts.bar_last   = bar_ff == BarBits'(BAR_COUNT - 1);

endmodule

// ===== hdl/stereo_peak_meter_auto_range.sv =====
// a plain frame gives no result; a last frame gives its levels result after two 24-step divides
// a last frame blocks the input until its levels result is loaded, mostly while the serial percent divider runs
// a due bar refresh gives 8 results, one per bar; each waits while the result side stalls
// reset: synchronous active-high, clears the control, peak, level and bar state, registers return to defaults
// ----------------------------------------------------------------------------
// stereo_peak_meter_auto_range
// stereo peak meter with auto-ranging full scale and eight-bar display
// ----------------------------------------------------------------------------
module stereo_peak_meter_auto_range
   import spmar_pkg::*;
#(
   parameter int BAR_COUNT      = BarCountDefault,
   parameter int SUBSAMPLE_TAPS = SubsampleTapsDefault
) (
   input  logic        clock,
   input  logic        reset,
   spmar_if.sink       req,
   spmar_if.source     rsp,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;
   rsp_type item;
   logic    rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{FloorPeakReset, DecayShiftReset, StaleWindowReset,
                     RefreshPeriodReset, RiseMinReset, FallMinReset};
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FLOOR:   cfg_ff.floor_peak <= csr_write_data;
            CSR_DECAY:   cfg_ff.decay_shift <= csr_write_data[3:0];
            CSR_STALE:   cfg_ff.stale_window_ms <= csr_write_data;
            CSR_REFRESH: cfg_ff.refresh_period_ms <= csr_write_data;
            CSR_RISE:    cfg_ff.rise_min_step <= csr_write_data[6:0];
            CSR_FALL:    cfg_ff.fall_min_step <= csr_write_data[6:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.rsp_load_levels || cmd.rsp_load_bar) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end

   spmar_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_busy(rsp_valid_ff && !rsp.ready),
      .sts, .cmd
   );

   spmar_dp #(.BAR_COUNT(BAR_COUNT), .SUBSAMPLE_TAPS(SUBSAMPLE_TAPS)) u_dp (
      .clock, .reset, .req_data(req.data), .cfg(cfg_ff),
      .cmd, .sts, .rsp_item(item)
   );

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = item;

endmodule

// ===== verif/spmar_meter_checker.sv =====
// ----------------------------------------------------------------------------
// spmar_meter_checker
// Watches the frame/refresh channel, the result channel and the register
// port of the stereo peak meter. It keeps its own copy of the meter state,
// works out the channel-level and bar results each transfer should cause,
// and compares every result transfer field by field with the oldest one.
// ----------------------------------------------------------------------------
module spmar_meter_checker
   import spmar_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data,
   output int          fail_count,
   output int          pending_count,
   output int          level_results,
   output int          bar_results
);

   cfg_type     cfg;
   logic [31:0] full_scale;
   logic [31:0] left_max, right_max;
   logic [31:0] step_len, skip_cnt;
   logic        in_buffer;
   logic [31:0] left_pct, right_pct;
   logic [31:0] signal_time, refresh_time;
   int          bars [8];
   rsp_type     expected_results [$];

   assign pending_count = expected_results.size();

   function automatic logic [31:0] abs_sample(input logic [15:0] s);
      return s[15] ? 32'h10000 - {16'd0, s} : {16'd0, s};
   endfunction

   function automatic logic [31:0] scale_percent(input logic [31:0] pk);
      logic [31:0] fl, dyn, decay, pct;
      fl = (cfg.floor_peak == 0) ? 32'd1 : {16'd0, cfg.floor_peak};
      dyn = full_scale;
      if (pk > dyn) begin
         dyn = pk;
      end else begin
         decay = dyn >> cfg.decay_shift;
         dyn = (dyn > decay + fl) ? dyn - decay : fl;
         if (pk > dyn) dyn = pk;
      end
      if (dyn < fl) dyn = fl;
      full_scale = dyn;
      pct = (pk * 100) / dyn;
      return (pct > 100) ? 32'd100 : pct;
   endfunction

   task automatic predict_item(input req_type it);
      rsp_type     r;
      logic [31:0] st, l, rr;
      logic        fresh;
      int          tgt [8];
      int          cur, old, stp, li, ri;
      if (it.func == FUNC_FRAME) begin
         if (!in_buffer) begin
            st = {17'd0, it.buffer_frames} / 64;
            step_len = (st == 0) ? 32'd1 : st;
            skip_cnt = 0;
            left_max = 0;
            right_max = 0;
            in_buffer = 1'b1;
         end
         if (skip_cnt == 0) begin
            l = abs_sample(it.left_sample);
            rr = abs_sample(it.right_sample);
            if (l > left_max) left_max = l;
            if (rr > right_max) right_max = rr;
         end
         skip_cnt++;
         if (skip_cnt >= step_len) skip_cnt = 0;
         if (!it.last_frame) return;
         left_pct = scale_percent(left_max);
         right_pct = scale_percent(right_max);
         signal_time = it.time_ms;
         in_buffer = 1'b0;
         r = '0;
         r.kind = KIND_LEVELS;
         r.left_percent = left_pct[6:0];
         r.right_percent = right_pct[6:0];
         r.last_result = 1'b1;
         expected_results.push_back(r);
         return;
      end
      if (it.time_ms - refresh_time < {16'd0, cfg.refresh_period_ms}) return;
      refresh_time = it.time_ms;
      fresh = (signal_time != 0) &&
              (it.time_ms - signal_time <= {16'd0, cfg.stale_window_ms});
      li = fresh ? int'(left_pct) : 0;
      ri = fresh ? int'(right_pct) : 0;
      tgt = '{li / 3, li / 2, (li * 3) / 4, li, ri, (ri * 3) / 4, ri / 2, ri / 3};
      for (int i = 0; i < 8; i++) begin
         cur = bars[i];
         old = cur;
         if (cur < tgt[i]) begin
            stp = tgt[i] - cur;
            if (int'(cfg.rise_min_step) > stp) stp = cfg.rise_min_step;
            cur = (cur + stp < tgt[i]) ? cur + stp : tgt[i];
         end else if (cur > tgt[i]) begin
            stp = (cur - tgt[i] + 1) / 2;
            if (int'(cfg.fall_min_step) > stp) stp = cfg.fall_min_step;
            cur = (cur - stp > tgt[i]) ? cur - stp : tgt[i];
         end
         bars[i] = cur;
         r = '0;
         r.kind = KIND_BAR;
         r.bar_index = i[2:0];
         r.bar_level = cur[6:0];
         r.bar_height = 6'(4 + (cur * 30) / 100);
         r.bar_changed = (cur != old);
         r.signal_fresh = fresh;
         r.last_result = (i == 7);
         expected_results.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         cfg <= '{FloorPeakReset, DecayShiftReset, StaleWindowReset,
                  RefreshPeriodReset, RiseMinReset, FallMinReset};
         full_scale = FullScaleReset;
         left_max = 0;
         right_max = 0;
         step_len = 0;
         skip_cnt = 0;
         in_buffer = 1'b0;
         left_pct = 0;
         right_pct = 0;
         signal_time = 0;
         refresh_time = 0;
         bars = '{default: 0};
         expected_results.delete();
         fail_count <= 0;
         level_results <= 0;
         bar_results <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FLOOR:   cfg.floor_peak <= csr_write_data;
               CSR_DECAY:   cfg.decay_shift <= csr_write_data[3:0];
               CSR_STALE:   cfg.stale_window_ms <= csr_write_data;
               CSR_REFRESH: cfg.refresh_period_ms <= csr_write_data;
               CSR_RISE:    cfg.rise_min_step <= csr_write_data[6:0];
               CSR_FALL:    cfg.fall_min_step <= csr_write_data[6:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_item(req_data);
         if (rsp_valid && rsp_ready) begin
            if (rsp_data.kind == KIND_BAR) bar_results <= bar_results + 1;
            else level_results <= level_results + 1;
            if (expected_results.size() == 0) begin
               $display("%0t: result with none expected, actual %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_results.pop_front();
               if (rsp_data.kind !== e.kind || rsp_data.left_percent !== e.left_percent ||
                   rsp_data.right_percent !== e.right_percent ||
                   rsp_data.bar_index !== e.bar_index ||
                   rsp_data.bar_level !== e.bar_level ||
                   rsp_data.bar_height !== e.bar_height ||
                   rsp_data.bar_changed !== e.bar_changed ||
                   rsp_data.signal_fresh !== e.signal_fresh ||
                   rsp_data.last_result !== e.last_result) begin
                  $display("%0t: mismatch, expected %p actual %p", $time, e, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== verif/tb_stereo_peak_meter_auto_range.sv =====
// ----------------------------------------------------------------------------
// tb_stereo_peak_meter_auto_range
// Drives sample buffers and bar refreshes into the peak meter under several
// register settings, with bursty input and a stalling result side; the
// checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_stereo_peak_meter_auto_range;
   import spmar_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [15:0] csr_write_data;
   int          fail_count, pending_count, level_results, bar_results;
   int          burst_left, idle_count, frames_sent, refreshes_sent;
   logic [31:0] now_ms;

   spmar_if #(.payload_type(req_type)) req_ch ();
   spmar_if #(.payload_type(rsp_type)) rsp_ch ();

   stereo_peak_meter_auto_range dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   spmar_meter_checker meter_check (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .fail_count(fail_count),
      .pending_count(pending_count), .level_results(level_results),
      .bar_results(bar_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side stall pattern
   always @(negedge clock) begin
      int phase;
      phase = ($time / 640) % 3;
      if (phase == 0) rsp_ch.ready <= 1'b1;
      else if (phase == 1) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      else rsp_ch.ready <= $urandom_range(0, 1);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_count <= 0;
      end else if (idle_count >= 20000) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   task automatic push(input req_type it);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= it;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(int'($urandom_range(0, 200)) - 100);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_frame(input logic [15:0] l, input logic [15:0] r,
                             input logic [14:0] bf, input logic lastf,
                             input logic [31:0] t);
      req_type it;
      it = '{FUNC_FRAME, l, r, bf, lastf, t};
      push(it);
      frames_sent++;
   endtask

   task automatic send_refresh(input logic [31:0] t);
      req_type it;
      it = '{FUNC_REFRESH, pick_sample(), pick_sample(), 15'($urandom),
             1'($urandom), t};
      push(it);
      refreshes_sent++;
   endtask

   task automatic send_buffer(input int n);
      logic [14:0] bf;
      bf = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'(n);
      for (int i = 0; i < n; i++)
         send_frame(pick_sample(), pick_sample(), (i == 0) ? bf : 15'($urandom),
                    i == n - 1, now_ms);
   endtask

   task automatic random_traffic(input int items);
      int sent;
      int n;
      sent = 0;
      while (sent < items) begin
         now_ms += $urandom_range(0, 60);
         if ($urandom_range(0, 9) == 0) now_ms += $urandom_range(200, 70000);
         if ($urandom_range(0, 2) == 0) begin
            send_refresh(now_ms);
            sent++;
         end else begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 140)
                                            : $urandom_range(1, 6);
            if (n > 6) n = $urandom_range(1, 4) + ((items - sent > 20) ? 0 : 0);
            send_buffer(n);
            sent += n;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_FLOOR;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      burst_left = 0;
      frames_sent = 0;
      refreshes_sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: refresh too soon, buffer ending at time zero, extremes
      send_refresh(32'd0);
      send_frame(16'h8000, 16'h7FFF, 15'd1, 1'b1, 32'd0);
      send_refresh(32'd40);
      send_frame(16'h7FFF, 16'h8000, 15'd0, 1'b1, 32'd50);
      send_refresh(32'd60);
      send_refresh(32'd100);
      send_frame(16'h0000, 16'hFFFF, 15'h7FFF, 1'b0, 32'd110);
      send_frame(16'h1234, 16'hFFFF, 15'd0, 1'b0, 32'd110);
      send_frame(16'h0001, 16'h0001, 15'd3, 1'b1, 32'd120);
      send_refresh(32'd140);
      send_refresh(32'd900);
      send_refresh(32'd940);
      send_frame(16'h0000, 16'h0000, 15'd64, 1'b1, 32'hFFFF_FFF0);
      send_refresh(32'h0000_0020);
      drain();

      now_ms = 32'd2000;
      random_traffic(25);
      drain();

      write_reg(CSR_FLOOR, 16'd0);
      write_reg(CSR_DECAY, 16'd0);
      write_reg(CSR_STALE, 16'd0);
      write_reg(CSR_REFRESH, 16'd0);
      write_reg(CSR_RISE, 16'd0);
      write_reg(CSR_FALL, 16'd0);
      random_traffic(25);
      drain();

      write_reg(CSR_FLOOR, 16'd32768);
      write_reg(CSR_DECAY, 16'd15);
      write_reg(CSR_STALE, 16'd65535);
      write_reg(CSR_REFRESH, 16'd65535);
      write_reg(CSR_RISE, 16'd100);
      write_reg(CSR_FALL, 16'd100);
      now_ms = 32'h8000_0000 | 32'($urandom);
      random_traffic(20);
      drain();

      write_reg(CSR_FLOOR, 16'($urandom_range(1, 32768)));
      write_reg(CSR_DECAY, 16'($urandom_range(0, 15)));
      write_reg(CSR_STALE, 16'($urandom_range(40, 400)));
      write_reg(CSR_REFRESH, 16'($urandom_range(0, 40)));
      write_reg(CSR_RISE, 16'($urandom_range(0, 100)));
      write_reg(CSR_FALL, 16'($urandom_range(0, 100)));
      random_traffic(30);
      drain();

      $display("covered %0d frames and %0d refreshes over four register settings",
               frames_sent, refreshes_sent);
      $display("checked %0d channel level results and %0d bar results",
               level_results, bar_results);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
